[src/tcw_pkg.sv]
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OUTROW_W = 5;
    localparam int OUTCOL_W = 7;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_entry;
        logic [OUTROW_W-1:0] cursor_row;
        logic [OUTCOL_W-1:0] cursor_col;
        logic                scrolled;
    } tcw_result_t;

endpackage

[src/text_console_writer.sv]
// An accepted transaction passes through S_ACT (RAM access) and S_FINISH (result
// hand-off) to the output register; a put that scrolls first passes through S_BLANK,
// where the new bottom row is blanked through the RAM port, one cell per cycle.
// A new transaction is accepted only in S_IDLE, once S_FINISH has handed off the last.
// Reset: cursor, row offset and color reset at once; a clearing pass then writes all
// ROWS * COLUMNS cells with s_axis_tready low.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [COLOR_W-1:0]  cfg_data,       // text_color
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,   // char_code, read_row, read_col, zero pad
    input  logic [0:0]          s_axis_tuser,   // cmd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata    // cell_entry, cursor_row, cursor_col,
                                                // scrolled, zero pad
);

    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    logic [COLOR_W-1:0] color_reg;
    logic               out_valid_reg;
    tcw_result_t        out_reg;
    tcw_result_t        res;
    logic               res_valid;
    logic               res_ready;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    assign cfg_ready     = 1'b1;
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.scrolled, out_reg.cursor_col,
                            out_reg.cursor_row, out_reg.cell_entry};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= RESET_COLOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                color_reg <= cfg_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (color_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser[0]),
        .in_char    (s_axis_tdata[7:0]),
        .in_row     (s_axis_tdata[12:8]),
        .in_col     (s_axis_tdata[19:13]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (ROWS * COLUMNS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[src/tcw_ram.sv]
module tcw_ram
    import tcw_pkg::*;
#(
    parameter int WIDTH = CELL_W,
    parameter int DEPTH = ROWS_DEF * COLUMNS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/tcw_engine.sv]
module tcw_engine
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [COLOR_W-1:0]                   text_color,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic [CHAR_W-1:0]                    in_char,
    input  logic [RROW_W-1:0]                    in_row,
    input  logic [RCOL_W-1:0]                    in_col,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output tcw_result_t                          res,
    output logic                                 ram_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      ram_waddr,
    output logic [CELL_W-1:0]                    ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      ram_raddr,
    input  logic [CELL_W-1:0]                    ram_rdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CROW_W     = $clog2(ROWS + 1);
    localparam int CCOL_W     = $clog2(COLUMNS + 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_BLANK  = 5'b00100,
        S_ACT    = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [CROW_W-1:0]   row_reg, row_next;
    logic [CCOL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic                scroll_reg, scroll_next;
    logic                cmd_reg, cmd_next;
    logic                inrange_reg, inrange_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [RROW_W-1:0]   rrow_reg, rrow_next;
    logic [RCOL_W-1:0]   rcol_reg, rcol_next;

    logic [ROW_W-1:0]    phys_src;
    logic [ROW_W:0]      phys_sum;
    logic [ROW_W-1:0]    phys_row;
    logic [ADDR_W-1:0]   row_base;
    logic [CROW_W-1:0]   wrap_row;
    logic [CCOL_W-1:0]   wrap_col;
    logic [ADDR_W-1:0]   col_addr;

    always_comb
    begin
        if (cmd_reg == CMD_READ)
        begin
            phys_src = ROW_W'(rrow_reg);
            col_addr = ADDR_W'(rcol_reg);
        end
        else
        begin
            phys_src = ROW_W'(row_reg);
            col_addr = ADDR_W'(col_reg);
        end
        phys_sum = {1'b0, phys_src} + {1'b0, top_reg};
        if (phys_sum >= (ROW_W + 1)'(ROWS))
        begin
            phys_sum = phys_sum - (ROW_W + 1)'(ROWS);
        end
        phys_row = phys_sum[ROW_W-1:0];
        row_base = ADDR_W'(phys_row) * ADDR_W'(COLUMNS);
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        top_next     = top_reg;
        scroll_next  = scroll_reg;
        cmd_next     = cmd_reg;
        inrange_next = inrange_reg;
        char_next    = char_reg;
        rrow_next    = rrow_reg;
        rcol_next    = rcol_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg;
        ram_wdata    = {RESET_COLOR, CH_BLANK};
        ram_re       = 1'b0;
        ram_raddr    = row_base + col_addr;
        wrap_row     = row_reg;
        wrap_col     = col_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next     = in_cmd;
                    char_next    = in_char;
                    rrow_next    = in_row;
                    rcol_next    = in_col;
                    inrange_next = (in_row < ROWS) && (in_col < COLUMNS);
                    cnt_next     = '0;
                    state_next   = S_ACT;
                    if (in_cmd == CMD_PUT)
                    begin
                        if (col_reg >= CCOL_W'(COLUMNS))
                        begin
                            wrap_col = '0;
                            wrap_row = row_reg + 1'b1;
                        end
                        if (wrap_row >= CROW_W'(ROWS))
                        begin
                            wrap_row    = CROW_W'(ROWS - 1);
                            scroll_next = 1'b1;
                            state_next  = S_BLANK;
                        end
                        row_next = wrap_row;
                        col_next = wrap_col;
                    end
                end
            end
            S_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(top_reg) * ADDR_W'(COLUMNS) + cnt_reg;
                ram_wdata = {text_color, CH_BLANK};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(COLUMNS - 1))
                begin
                    cnt_next   = '0;
                    top_next   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_FINISH;
                if (cmd_reg == CMD_READ)
                begin
                    ram_re = inrange_reg;
                end
                else if (char_reg == CH_NEWLINE)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else if (char_reg == CH_BACKSPACE)
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_base + col_addr;
                    ram_wdata = {text_color, char_reg};
                    col_next  = col_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    scroll_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.cell_entry = (cmd_reg == CMD_READ && inrange_reg) ? ram_rdata : '0;
        res.cursor_row = OUTROW_W'(row_reg);
        res.cursor_col = OUTCOL_W'(col_reg);
        res.scrolled   = scroll_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            top_reg    <= '0;
            scroll_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            top_reg    <= top_next;
            scroll_reg <= scroll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        inrange_reg <= inrange_next;
        char_reg    <= char_next;
        rrow_reg    <= rrow_next;
        rcol_reg    <= rcol_next;
    end

endmodule
